// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants and types for the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int NUM_PAGES  = 16384;
	localparam int MAX_ORDER  = 10;
	localparam int PAGE_BYTES = 4096;

	localparam int PAGE_W = $clog2(NUM_PAGES);
	localparam int PTR_W  = PAGE_W + 1;
	localparam int ORD_W  = 4;
	localparam int BYTE_W = 32;

	localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_PAGES);

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_MEM    = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef struct packed {
		logic             on_list;
		logic [ORD_W-1:0] order;
		logic [PTR_W-1:0] next;
	} page_word_t;

	localparam int WORD_W = $bits(page_word_t);

endpackage

// ===== design/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// buddy allocator over a page array with one lifo free list per order
// ----------------------------------------------------------------------------
// usage:
//   input channel carries mode, request_bytes and block_index; one beat is
//   taken when in_valid is high and in_stall is low. output channel carries
//   result_index, result_order and status, one beat per input beat.
//   page state (next link, order, free flag) lives in one ram with a
//   registered read; list heads are flops. the sequencer reads, modifies and
//   writes back one page word per step.
//   allocate pops the first non-empty list at or above the fitting order
//   and splits down one order per step, pushing each lower half; a rejected
//   request goes straight to the output, and a double free of a listed block
//   is caught at its first page read. free looks up the buddy and, per merge,
//   walks that order's list to unlink it, bounded by the list length. one
//   request is in flight at a time.
//   after reset the page ram is swept once, every page word, while in_stall
//   stays high. a finished beat waits in the output register while the
//   receiver stalls; the next request is taken meanwhile, and its result
//   waits until the output register is free.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [31:0]                 request_bytes,
	input  logic [bpa_pkg::PAGE_W-1:0]  block_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bpa_pkg::PAGE_W-1:0]  result_index,
	output logic [bpa_pkg::ORD_W-1:0]   result_order,
	output logic [1:0]                  status
);
	import bpa_pkg::*;

	typedef enum logic [14:0] {
		S_CLR     = 15'h0001,
		S_IDLE    = 15'h0002,
		S_A_POP   = 15'h0004,
		S_A_SPLIT = 15'h0008,
		S_A_FIN   = 15'h0010,
		S_F_RD    = 15'h0020,
		S_F_BUD   = 15'h0040,
		S_F_CHK   = 15'h0080,
		S_F_UL    = 15'h0100,
		S_F_ULRD  = 15'h0200,
		S_F_HI    = 15'h0400,
		S_F_LO    = 15'h0800,
		S_F_PUSH  = 15'h1000,
		S_DONE    = 15'h2000,
		S_SPARE   = 15'h4000
	} state_t;

	state_t state_q;

	logic [PTR_W-1:0]  head_q [MAX_ORDER+1];
	logic [PAGE_W-1:0] clr_q;
	logic [PTR_W-1:0]  p_q, bi_q, bnext_q, cur_q, prev_q;
	logic [ORD_W-1:0]  j_q, ord_q, pord_q;
	page_word_t        prevw_q;
	logic [PTR_W-1:0]  steps_q;

	logic [PAGE_W-1:0] res_idx_q;
	logic [ORD_W-1:0]  res_ord_q;
	status_t           res_st_q;

	logic              out_valid_q;
	logic [PAGE_W-1:0] out_idx_q;
	logic [ORD_W-1:0]  out_ord_q;
	status_t           out_st_q;

	logic              we, re;
	logic [PAGE_W-1:0] waddr, raddr;
	page_word_t        wdata, rdata;
	logic [WORD_W-1:0] rdata_raw;

	bpa_ram #(.WIDTH(WORD_W), .DEPTH(NUM_PAGES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (WORD_W'(wdata)),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata_raw)
	);
	assign rdata = page_word_t'(rdata_raw);

	// size to order and first non-empty list at or above it
	logic [ORD_W-1:0] fit_ord, src_ord;
	logic             fit_ok, src_ok;

	always_comb begin
		fit_ord = '0;
		fit_ok  = 1'b0;
		for (int o = MAX_ORDER; o >= 0; o--) begin
			if ({1'b0, request_bytes} <= (33'(PAGE_BYTES) << o)) begin
				fit_ord = ORD_W'(o);
				fit_ok  = 1'b1;
			end
		end
		src_ord = '0;
		src_ok  = 1'b0;
		for (int o = MAX_ORDER; o >= 0; o--) begin
			if (ORD_W'(o) >= fit_ord && head_q[o] != NIL) begin
				src_ord = ORD_W'(o);
				src_ok  = 1'b1;
			end
		end
	end

	logic [PTR_W-1:0] clr_next, bud, hi_pg, lo_pg, split_step;
	logic [ORD_W-1:0] j_dec, ord_inc;
	logic [ORD_W-1:0] ord_clamp;

	assign clr_next   = PTR_W'(clr_q) + PTR_W'(1 << MAX_ORDER);
	assign bud        = p_q ^ (PTR_W'(1) << ord_q);
	assign hi_pg      = bi_q[ord_q] ? bi_q : p_q;
	assign lo_pg      = bi_q[ord_q] ? p_q : bi_q;
	assign j_dec      = j_q - ORD_W'(1);
	assign split_step = PTR_W'(1) << j_dec;
	assign ord_inc    = ord_q + ORD_W'(1);
	assign ord_clamp  = (rdata.order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : rdata.order;

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = p_q[PAGE_W-1:0];
		wdata = '{on_list: 1'b0, order: '0, next: NIL};
		re    = 1'b0;
		raddr = p_q[PAGE_W-1:0];
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q[MAX_ORDER-1:0] == '0) begin
					wdata.on_list = 1'b1;
					wdata.order   = ORD_W'(MAX_ORDER);
					wdata.next    = (clr_next < NIL) ? clr_next : NIL;
				end
			end
			S_IDLE: begin
				re = in_valid;
				if (mode == MODE_ALLOC) begin
					raddr = head_q[src_ord][PAGE_W-1:0];
				end else begin
					raddr = block_index;
				end
			end
			S_A_POP: begin
				we          = 1'b1;
				wdata.order = rdata.order;
			end
			S_A_SPLIT: begin
				if (j_q > ord_q) begin
					we    = (p_q < NIL);
					wdata = '{on_list: 1'b1, order: j_dec, next: head_q[j_dec]};
				end else begin
					re = (p_q < NIL);
				end
			end
			S_A_FIN: begin
				we    = 1'b1;
				wdata = '{on_list: rdata.on_list, order: ord_q, next: rdata.next};
			end
			S_F_BUD: begin
				re    = (ord_q < ORD_W'(MAX_ORDER)) && (bud < NIL);
				raddr = bud[PAGE_W-1:0];
			end
			S_F_CHK: begin
				if (rdata.on_list && rdata.order == ord_q) begin
					we          = 1'b1;
					wdata.order = pord_q;
				end
			end
			S_F_UL: begin
				if (cur_q < NIL && steps_q < PTR_W'(NUM_PAGES)) begin
					if (cur_q == bi_q) begin
						we    = (prev_q != NIL);
						waddr = prev_q[PAGE_W-1:0];
						wdata = '{on_list: prevw_q.on_list, order: prevw_q.order,
							next: bnext_q};
					end else begin
						re    = 1'b1;
						raddr = cur_q[PAGE_W-1:0];
					end
				end
			end
			S_F_HI: begin
				we    = 1'b1;
				waddr = hi_pg[PAGE_W-1:0];
			end
			S_F_LO: begin
				we          = 1'b1;
				waddr       = lo_pg[PAGE_W-1:0];
				wdata.order = ord_inc;
			end
			S_F_PUSH: begin
				we    = 1'b1;
				wdata = '{on_list: 1'b1, order: ord_q, next: head_q[ord_q]};
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			for (int o = 0; o <= MAX_ORDER; o++) begin
				head_q[o] <= (o == MAX_ORDER) ? '0 : NIL;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PAGE_W'(1);
					if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						res_idx_q <= '0;
						res_ord_q <= '0;
						if (mode == MODE_ALLOC) begin
							if (!fit_ok) begin
								res_st_q <= ST_TOO_LARGE;
								state_q  <= S_DONE;
							end else if (!src_ok) begin
								res_st_q <= ST_NO_MEM;
								state_q  <= S_DONE;
							end else begin
								res_st_q <= ST_OK;
								p_q      <= head_q[src_ord];
								j_q      <= src_ord;
								ord_q    <= fit_ord;
								state_q  <= S_A_POP;
							end
						end else begin
							res_st_q <= ST_OK;
							p_q      <= {1'b0, block_index};
							state_q  <= S_F_RD;
						end
					end
				end
				S_A_POP: begin
					head_q[j_q] <= rdata.next;
					state_q     <= S_A_SPLIT;
				end
				S_A_SPLIT: begin
					if (j_q > ord_q) begin
						if (p_q < NIL) begin
							head_q[j_dec] <= p_q;
						end
						p_q <= p_q + split_step;
						j_q <= j_dec;
					end else if (p_q < NIL) begin
						state_q <= S_A_FIN;
					end else begin
						res_st_q <= ST_NO_MEM;
						state_q  <= S_DONE;
					end
				end
				S_A_FIN: begin
					res_idx_q <= p_q[PAGE_W-1:0];
					res_ord_q <= ord_q;
					state_q   <= S_DONE;
				end
				S_F_RD: begin
					if (rdata.on_list) begin
						res_st_q  <= ST_BAD_FREE;
						res_idx_q <= p_q[PAGE_W-1:0];
						res_ord_q <= rdata.order;
						state_q   <= S_DONE;
					end else begin
						pord_q  <= rdata.order;
						ord_q   <= ord_clamp;
						state_q <= S_F_BUD;
					end
				end
				S_F_BUD: begin
					bi_q <= bud;
					if (ord_q < ORD_W'(MAX_ORDER) && bud < NIL) begin
						state_q <= S_F_CHK;
					end else begin
						state_q <= S_F_PUSH;
					end
				end
				S_F_CHK: begin
					if (rdata.on_list && rdata.order == ord_q) begin
						bnext_q <= rdata.next;
						cur_q   <= head_q[ord_q];
						prev_q  <= NIL;
						steps_q <= '0;
						state_q <= S_F_UL;
					end else begin
						state_q <= S_F_PUSH;
					end
				end
				S_F_UL: begin
					if (cur_q < NIL && steps_q < PTR_W'(NUM_PAGES)) begin
						if (cur_q == bi_q) begin
							if (prev_q == NIL) begin
								head_q[ord_q] <= bnext_q;
							end
							state_q <= S_F_HI;
						end else begin
							state_q <= S_F_ULRD;
						end
					end else begin
						res_st_q  <= ST_BAD_FREE;
						res_idx_q <= p_q[PAGE_W-1:0];
						res_ord_q <= ord_q;
						state_q   <= S_DONE;
					end
				end
				S_F_ULRD: begin
					prev_q  <= cur_q;
					prevw_q <= rdata;
					cur_q   <= rdata.next;
					steps_q <= steps_q + PTR_W'(1);
					state_q <= S_F_UL;
				end
				S_F_HI: begin
					state_q <= S_F_LO;
				end
				S_F_LO: begin
					p_q     <= lo_pg;
					pord_q  <= ord_inc;
					ord_q   <= ord_inc;
					state_q <= S_F_BUD;
				end
				S_F_PUSH: begin
					head_q[ord_q] <= p_q;
					res_idx_q     <= p_q[PAGE_W-1:0];
					res_ord_q     <= ord_q;
					state_q       <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= res_idx_q;
						out_ord_q   <= res_ord_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_index = out_idx_q;
	assign result_order = out_ord_q;
	assign status       = out_st_q;

`ifndef SYNTHESIS
	a_clear_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> in_stall)
		else $error("input taken during clearing sweep");

	a_too_large_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_TOO_LARGE |-> result_index == '0 && result_order == '0)
		else $error("rejected request carries a block");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_F_ULRD |-> steps_q < PTR_W'(NUM_PAGES))
		else $error("list walk past its bound");

	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> result_order <= ORD_W'(MAX_ORDER))
		else $error("block order out of range");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && !(out_valid_q && out_stall) |=> state_q == S_IDLE && out_valid_q)
		else $error("finished beat not delivered");
`endif

endmodule

// ===== dv/bpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_checker
// watches both channels of the buddy page allocator, keeps its own copy of
// the free lists and page records, predicts each result beat and compares
// ----------------------------------------------------------------------------
module bpa_checker
	import bpa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                mode,
	input  logic [31:0]         request_bytes,
	input  logic [PAGE_W-1:0]   block_index,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [PAGE_W-1:0]   result_index,
	input  logic [ORD_W-1:0]    result_order,
	input  logic [1:0]          status,
	output int                  fail_count,
	output int                  pending
);

	typedef struct packed {
		logic [PAGE_W-1:0] idx;
		logic [ORD_W-1:0]  ord;
		status_t           st;
	} alloc_result_t;

	int            head_of[MAX_ORDER+1];
	int            link_of[NUM_PAGES];
	int            order_of[NUM_PAGES];
	bit            listed[NUM_PAGES];
	alloc_result_t want_q[$];
	int            n_taken;
	int            n_seen;

	assign pending = n_taken - n_seen;

	function automatic void list_push(int o, int p);
		link_of[p] = head_of[o];
		head_of[o] = p;
		listed[p] = 1;
	endfunction

	function automatic int list_pop(int o);
		int h;
		h = head_of[o];
		if (h >= NUM_PAGES) return NUM_PAGES;
		head_of[o] = link_of[h];
		link_of[h] = NUM_PAGES;
		listed[h] = 0;
		return h;
	endfunction

	function automatic bit list_unlink(int o, int target);
		int prev, cur, steps;
		prev = NUM_PAGES;
		cur = head_of[o];
		steps = 0;
		while (cur < NUM_PAGES && steps < NUM_PAGES) begin
			if (cur == target) begin
				if (prev == NUM_PAGES) head_of[o] = link_of[cur];
				else link_of[prev] = link_of[cur];
				link_of[cur] = NUM_PAGES;
				listed[cur] = 0;
				return 1;
			end
			prev = cur;
			cur = link_of[cur];
			steps++;
		end
		return 0;
	endfunction

	function automatic void clear_pages();
		int nblk;
		nblk = NUM_PAGES >> MAX_ORDER;
		foreach (head_of[i]) head_of[i] = NUM_PAGES;
		for (int i = 0; i < NUM_PAGES; i++) begin
			link_of[i] = NUM_PAGES;
			order_of[i] = 0;
			listed[i] = 0;
		end
		for (int i = 0; i < nblk; i++) begin
			link_of[i << MAX_ORDER] = (i + 1 < nblk) ? (i + 1) << MAX_ORDER : NUM_PAGES;
			order_of[i << MAX_ORDER] = MAX_ORDER;
			listed[i << MAX_ORDER] = 1;
		end
		head_of[MAX_ORDER] = 0;
	endfunction

	function automatic alloc_result_t serve(logic m, logic [31:0] nbytes,
			logic [PAGE_W-1:0] bidx);
		alloc_result_t r;
		int o, j, p, bud, stp;
		r = '0;
		r.st = ST_OK;
		if (m == MODE_ALLOC) begin
			o = 0;
			while (o <= MAX_ORDER && (64'(PAGE_BYTES) << o) < 64'(nbytes)) o++;
			if (o > MAX_ORDER) begin
				r.st = ST_TOO_LARGE;
				return r;
			end
			p = list_pop(o);
			if (p == NUM_PAGES) begin
				for (j = o + 1; j <= MAX_ORDER; j++) begin
					p = list_pop(j);
					if (p != NUM_PAGES) break;
				end
				if (p == NUM_PAGES) begin
					r.st = ST_NO_MEM;
					return r;
				end
				while (j > o) begin
					j--;
					order_of[p] = j;
					list_push(j, p);
					p += 1 << j;
				end
			end
			if (p >= NUM_PAGES) begin
				r.st = ST_NO_MEM;
				return r;
			end
			order_of[p] = o;
			r.idx = PAGE_W'(p);
			r.ord = ORD_W'(o);
		end else if (listed[bidx]) begin
			r.st = ST_BAD_FREE;
			r.idx = bidx;
			r.ord = ORD_W'(order_of[bidx]);
		end else begin
			p = int'(bidx);
			o = order_of[p];
			if (o > MAX_ORDER) o = MAX_ORDER;
			forever begin
				stp = 1 << o;
				bud = ((p >> o) & 1) ? p - stp : p + stp;
				if (o >= MAX_ORDER || bud >= NUM_PAGES || !listed[bud]
						|| order_of[bud] != o) begin
					order_of[p] = o;
					list_push(o, p);
					break;
				end
				listed[p] = 0;
				link_of[p] = NUM_PAGES;
				if (!list_unlink(o, bud)) begin
					r.st = ST_BAD_FREE;
					break;
				end
				if ((bud >> o) & 1) order_of[bud] = 0;
				else begin
					order_of[p] = 0;
					p = bud;
				end
				o++;
				order_of[p] = o;
			end
			r.idx = PAGE_W'(p);
			r.ord = ORD_W'(o);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t w;
		if (!arst_n) begin
			clear_pages();
			want_q.delete();
			n_taken <= 0;
			n_seen <= 0;
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				want_q.push_back(serve(mode, request_bytes, block_index));
				n_taken <= n_taken + 1;
			end
			if (out_valid && !out_stall) begin
				n_seen <= n_seen + 1;
				if (want_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat idx=%0d ord=%0d st=%0d",
							result_index, result_order, status);
					fail_count <= fail_count + 1;
				end else begin
					w = want_q.pop_front();
					if (w.idx !== result_index || w.ord !== result_order
							|| w.st !== status) begin
						if (fail_count < 10)
							$display("mismatch: want idx=%0d ord=%0d st=%0d, got idx=%0d ord=%0d st=%0d",
								w.idx, w.ord, w.st, result_index, result_order, status);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives allocate and free requests into the buddy page allocator with random
// gaps and output stalls; results are predicted and checked by bpa_checker
// ----------------------------------------------------------------------------
module testbench;
	import bpa_pkg::*;

	localparam int IDLE_PCT   = 17;
	localparam int STALL_LIMIT = 200000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              mode;
	logic [31:0]       request_bytes;
	logic [PAGE_W-1:0] block_index;
	logic              out_valid;
	logic              out_stall;
	logic [PAGE_W-1:0] result_index;
	logic [ORD_W-1:0]  result_order;
	logic [1:0]        status;
	int                fail_count;
	int                pending;

	bit                gaps_on;
	int                quiet_cycles;
	logic              mode_q[$];
	int                live_blocks[$];
	int                freed_blocks[$];

	buddy_page_allocator dut (.*);

	bpa_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// track blocks handed out so frees are mostly well-formed
	always @(posedge clk) begin
		logic m;
		if (arst_n) begin
			if (in_valid && !in_stall) mode_q.push_back(mode);
			if (out_valid && !out_stall && mode_q.size() > 0) begin
				m = mode_q.pop_front();
				if (m == MODE_ALLOC && status == ST_OK)
					live_blocks.push_back(int'(result_index));
			end
			out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send(logic m, logic [31:0] nbytes, logic [PAGE_W-1:0] bidx);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		request_bytes <= nbytes;
		block_index <= bidx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic alloc_bytes(logic [31:0] nbytes);
		send(MODE_ALLOC, nbytes, PAGE_W'($urandom));
	endtask

	task automatic free_block(int bidx);
		send(MODE_FREE, $urandom, PAGE_W'(bidx));
		freed_blocks.push_back(bidx);
		if (freed_blocks.size() > 64) void'(freed_blocks.pop_front());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic free_live_at(int k);
		int b;
		b = live_blocks[k];
		live_blocks.delete(k);
		free_block(b);
	endtask

	initial begin
		int r;
		int sz;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ALLOC;
		request_bytes = '0;
		block_index = '0;
		out_stall = 1'b0;
		gaps_on = 1'b1;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: size edges, exhaustion, too large, merges, double free
		alloc_bytes(32'd0);
		alloc_bytes(32'd4096);
		alloc_bytes(32'd4097);
		alloc_bytes(32'(PAGE_BYTES << MAX_ORDER) + 32'd1);
		alloc_bytes(32'hFFFF_FFFF);
		for (int i = 0; i < 16; i++) alloc_bytes(32'(PAGE_BYTES << MAX_ORDER));
		drain();
		while (live_blocks.size() > 0) free_live_at(0);
		drain();
		free_block(freed_blocks[freed_blocks.size() - 1]);
		free_block(16383);
		drain();

		// random: mostly alloc/free pairs, some garbage frees and oversize asks
		for (int n = 0; n < 1550; n++) begin
			gaps_on = !(n >= 600 && n < 900);
			r = $urandom_range(99);
			if (r < 5) free_block(int'($urandom_range(NUM_PAGES - 1)));
			else if (r < 8) alloc_bytes($urandom);
			else if (r < 10 && freed_blocks.size() > 0)
				free_block(freed_blocks[$urandom_range(freed_blocks.size() - 1)]);
			else if (r < 55 && live_blocks.size() > 0)
				free_live_at($urandom_range(live_blocks.size() - 1));
			else begin
				sz = ($urandom_range(9) == 0) ? $urandom_range(PAGE_BYTES << MAX_ORDER)
					: $urandom_range(4 * PAGE_BYTES);
				alloc_bytes(32'(sz));
			end
		end
		gaps_on = 1'b1;
		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
